@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers, reset disables the check.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	`ASSERT_CLK(lbl, clk, rst_n, !(expr), msg)

`endif

@@ rtl/fdsc_pkg.sv @@
// ----------------------------------------------------------------------------
// fdsc_pkg
// Types and codes for the 3.5-inch drive sense/control block.
// ----------------------------------------------------------------------------
package fdsc_pkg;

	// request commands
	localparam logic [2:0] CMD_LINE    = 3'd0;
	localparam logic [2:0] CMD_HSEL    = 3'd1;
	localparam logic [2:0] CMD_TICK    = 3'd2;
	localparam logic [2:0] CMD_MOUNT   = 3'd3;
	localparam logic [2:0] CMD_UNMOUNT = 3'd4;

	localparam logic [1:0] LINE_STROBE = 2'd3;

	// selector is CA2:CA1:CA0:SEL
	localparam logic [3:0] SEL_DIR      = 4'b0000;
	localparam logic [3:0] SEL_PRESENT  = 4'b0001;
	localparam logic [3:0] SEL_STEP     = 4'b0010;
	localparam logic [3:0] SEL_WPROT    = 4'b0011;
	localparam logic [3:0] SEL_MOTOR_ON = 4'b0100;
	localparam logic [3:0] SEL_TRACK0   = 4'b0101;
	localparam logic [3:0] SEL_SWAPPED  = 4'b0110;
	localparam logic [3:0] SEL_DIR_OUT  = 4'b1000;
	localparam logic [3:0] SEL_CLR_SWAP = 4'b1001;
	localparam logic [3:0] SEL_SIDES    = 4'b1100;
	localparam logic [3:0] SEL_READY    = 4'b1101;
	localparam logic [3:0] SEL_EJECT    = 4'b1110;

	// configuration register indexes
	localparam logic [2:0] REG_WPROT  = 3'd0;
	localparam logic [2:0] REG_SIDES  = 3'd1;
	localparam logic [2:0] REG_LAST   = 3'd2;
	localparam logic [2:0] REG_SETTLE = 3'd3;
	localparam logic [2:0] REG_NEAR   = 3'd4;
	localparam logic [2:0] REG_FAR    = 3'd5;
	localparam logic [2:0] REG_SPINUP = 3'd6;

	localparam logic [6:0]  LAST_TRACK_RST = 7'd79;
	localparam logic [15:0] SETTLE_RST     = 16'd300;
	localparam logic [15:0] NEAR_RST       = 16'd1000;
	localparam logic [15:0] FAR_RST        = 16'd5000;
	localparam logic [15:0] SPINUP_RST     = 16'd5000;

	typedef struct packed {
		logic [1:0] pad;
		logic       level;
		logic [1:0] line;
		logic [2:0] cmd;
	} req_t;

	typedef struct packed {
		logic [5:0] pad;
		logic       motor_running;
		logic       head_side;
		logic [6:0] track;
		logic       sense;
	} res_t;

endpackage

@@ rtl/floppy_drive_sense_control.sv @@
// ----------------------------------------------------------------------------
// floppy_drive_sense_control
// Control lines, stepper, motor and status decode of a 3.5-inch drive.
// ----------------------------------------------------------------------------
// channel   dir  width  contents
// s_axis    in   8      cmd, line, level
// m_axis    out  16     sense, track, head_side, motor_running
// apb       in   32     seven config registers at 4*i
//
// One request per cycle while s_axis_tready is high; the result is registered.
// The state update and status decode are a single combinational pass.
// Output register plus a one-entry skid: a request taken while the output
// register is stalled goes to the skid, and s_axis_tready then stays low until
// the skid moves into the output register on the next m_axis accept.
// arst_n clears drive state and loads register defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module floppy_drive_sense_control (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // cmd[2:0], line[4:3], level[5], zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata    // sense[0], track[7:1], head_side[8],
	                                    // motor_running[9], zero
);

	// configuration
	logic        wprot_q, sides_q;
	logic [6:0]  last_track_q;
	logic [15:0] settle_q, near_q, far_q, spinup_q;

	// drive state
	logic [3:0]  sel_q, sel_d;
	logic        strobe_q, strobe_d;
	logic        dir_out_q, dir_out_d;
	logic        present_q, present_d;
	logic        swapped_q, swapped_d;
	logic        motor_q, motor_d;
	logic [6:0]  track_q, track_d;
	logic        side_q, side_d;
	logic        ready_q, ready_d;
	logic        stepping_q, stepping_d;
	logic [15:0] rcnt_q, rcnt_d;
	logic [15:0] scnt_q, scnt_d;

	// output buffer
	logic        out_v_q, skid_v_q;
	fdsc_pkg::res_t out_q, skid_q, res_d;

	fdsc_pkg::req_t req;
	logic        in_acc, out_acc, main_free, cfg_wr;
	logic [7:0]  tgt_raw;
	logic [6:0]  tgt_trk;
	logic        tgt_far;
	logic [15:0] tgt_ready;
	logic        sense_d;

	assign pready        = 1'b1;
	assign cfg_wr        = psel & penable & pwrite & pready;
	assign req           = s_axis_tdata;
	assign s_axis_tready = !skid_v_q;
	assign in_acc        = s_axis_tvalid & s_axis_tready;
	assign out_acc       = m_axis_tvalid & m_axis_tready;
	assign main_free     = out_acc | !out_v_q;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wprot_q      <= 1'b0;
			sides_q      <= 1'b1;
			last_track_q <= fdsc_pkg::LAST_TRACK_RST;
			settle_q     <= fdsc_pkg::SETTLE_RST;
			near_q       <= fdsc_pkg::NEAR_RST;
			far_q        <= fdsc_pkg::FAR_RST;
			spinup_q     <= fdsc_pkg::SPINUP_RST;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				fdsc_pkg::REG_WPROT:  wprot_q      <= pwdata[0];
				fdsc_pkg::REG_SIDES:  sides_q      <= pwdata[0];
				fdsc_pkg::REG_LAST:   last_track_q <= pwdata[6:0];
				fdsc_pkg::REG_SETTLE: settle_q     <= pwdata[15:0];
				fdsc_pkg::REG_NEAR:   near_q       <= pwdata[15:0];
				fdsc_pkg::REG_FAR:    far_q        <= pwdata[15:0];
				fdsc_pkg::REG_SPINUP: spinup_q     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			fdsc_pkg::REG_WPROT:  prdata = {31'd0, wprot_q};
			fdsc_pkg::REG_SIDES:  prdata = {31'd0, sides_q};
			fdsc_pkg::REG_LAST:   prdata = {25'd0, last_track_q};
			fdsc_pkg::REG_SETTLE: prdata = {16'd0, settle_q};
			fdsc_pkg::REG_NEAR:   prdata = {16'd0, near_q};
			fdsc_pkg::REG_FAR:    prdata = {16'd0, far_q};
			fdsc_pkg::REG_SPINUP: prdata = {16'd0, spinup_q};
			default:              prdata = 32'd0;
		endcase
	end

	// step target, clamped to 0..last_track
	always_comb begin
		if (dir_out_q)
			tgt_raw = (track_q == 7'd0) ? 8'd0 : {1'b0, track_q} - 8'd1;
		else
			tgt_raw = {1'b0, track_q} + 8'd1;
	end
	assign tgt_trk   = (tgt_raw > {1'b0, last_track_q}) ? last_track_q : tgt_raw[6:0];
	assign tgt_far   = tgt_trk[6:4] != track_q[6:4];
	assign tgt_ready = tgt_far ? far_q : near_q;

	always_comb begin
		sel_d      = sel_q;
		strobe_d   = strobe_q;
		dir_out_d  = dir_out_q;
		present_d  = present_q;
		swapped_d  = swapped_q;
		motor_d    = motor_q;
		track_d    = track_q;
		side_d     = side_q;
		ready_d    = ready_q;
		stepping_d = stepping_q;
		rcnt_d     = rcnt_q;
		scnt_d     = scnt_q;

		unique case (req.cmd)
			fdsc_pkg::CMD_LINE: begin
				if (req.line == fdsc_pkg::LINE_STROBE) begin
					strobe_d = req.level;
					if (!strobe_q && req.level) begin
						unique case (sel_q)
							fdsc_pkg::SEL_DIR:      dir_out_d = 1'b0;
							fdsc_pkg::SEL_DIR_OUT:  dir_out_d = 1'b1;
							fdsc_pkg::SEL_CLR_SWAP: swapped_d = 1'b0;
							fdsc_pkg::SEL_STEP: begin
								if (tgt_trk != track_q) begin
									rcnt_d     = tgt_ready;
									ready_d    = tgt_ready == 16'd0;
									scnt_d     = settle_q;
									stepping_d = settle_q != 16'd0;
									track_d    = tgt_trk;
								end
							end
							fdsc_pkg::SEL_MOTOR_ON: begin
								motor_d = 1'b1;
								rcnt_d  = spinup_q;
								ready_d = spinup_q == 16'd0;
							end
							fdsc_pkg::SEL_SIDES: begin
								// motor off
								motor_d = 1'b0;
								rcnt_d  = 16'd0;
								ready_d = 1'b0;
							end
							fdsc_pkg::SEL_EJECT: begin
								present_d = 1'b0;
								swapped_d = 1'b1;
							end
							default: ;
						endcase
					end
				end else begin
					sel_d[req.line + 2'd1] = req.level;
				end
			end
			fdsc_pkg::CMD_HSEL: sel_d[0] = req.level;
			fdsc_pkg::CMD_TICK: begin
				if (rcnt_q != 16'd0) begin
					rcnt_d = rcnt_q - 16'd1;
					if (rcnt_q == 16'd1)
						ready_d = 1'b1;
				end
				if (scnt_q != 16'd0) begin
					scnt_d = scnt_q - 16'd1;
					if (scnt_q == 16'd1)
						stepping_d = 1'b0;
				end
			end
			fdsc_pkg::CMD_MOUNT: begin
				present_d = 1'b1;
				swapped_d = 1'b0;
				track_d   = 7'd0;
				side_d    = 1'b0;
			end
			fdsc_pkg::CMD_UNMOUNT: begin
				present_d = 1'b0;
				motor_d   = 1'b0;
				swapped_d = 1'b1;
			end
			default: ;
		endcase

		// status decode on the updated state; 1000/1001 also latch the side
		unique case (sel_d)
			fdsc_pkg::SEL_DIR:      sense_d = dir_out_d;
			fdsc_pkg::SEL_PRESENT:  sense_d = !present_d;
			fdsc_pkg::SEL_STEP:     sense_d = !stepping_d;
			fdsc_pkg::SEL_WPROT:    sense_d = !wprot_q;
			fdsc_pkg::SEL_MOTOR_ON: sense_d = !motor_d;
			fdsc_pkg::SEL_TRACK0:   sense_d = track_d != 7'd0;
			fdsc_pkg::SEL_SWAPPED:  sense_d = swapped_d;
			fdsc_pkg::SEL_DIR_OUT: begin
				sense_d = 1'b0;
				side_d  = 1'b0;
			end
			fdsc_pkg::SEL_CLR_SWAP: begin
				sense_d = 1'b0;
				side_d  = 1'b1;
			end
			fdsc_pkg::SEL_SIDES:    sense_d = sides_q;
			fdsc_pkg::SEL_READY:    sense_d = !ready_d;
			default:                sense_d = 1'b0;
		endcase

		res_d               = '0;
		res_d.sense         = sense_d;
		res_d.track         = track_d;
		res_d.head_side     = side_d;
		res_d.motor_running = motor_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q      <= '0;
			strobe_q   <= 1'b0;
			dir_out_q  <= 1'b0;
			present_q  <= 1'b0;
			swapped_q  <= 1'b0;
			motor_q    <= 1'b0;
			track_q    <= '0;
			side_q     <= 1'b0;
			ready_q    <= 1'b0;
			stepping_q <= 1'b0;
			rcnt_q     <= '0;
			scnt_q     <= '0;
		end else if (in_acc) begin
			sel_q      <= sel_d;
			strobe_q   <= strobe_d;
			dir_out_q  <= dir_out_d;
			present_q  <= present_d;
			swapped_q  <= swapped_d;
			motor_q    <= motor_d;
			track_q    <= track_d;
			side_q     <= side_d;
			ready_q    <= ready_d;
			stepping_q <= stepping_d;
			rcnt_q     <= rcnt_d;
			scnt_q     <= scnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (main_free) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= in_acc;
			end
		end else if (in_acc) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_free)
			out_q <= skid_v_q ? skid_q : res_d;
		if (in_acc && !main_free)
			skid_q <= res_d;
	end

	`ASSERT_CLK(a_stepping_has_count, clk, arst_n, stepping_q |-> (scnt_q != 16'd0),
		"stepping flag set with idle settle count")
	`ASSERT_CLK(a_ready_count_not_ready, clk, arst_n, (rcnt_q != 16'd0) |-> !ready_q,
		"ready flag set while ready count still running")
	`ASSERT_NEVER(a_skid_without_main, clk, arst_n, skid_v_q && !out_v_q,
		"skid entry held with output register empty")
	`ASSERT_CLK(a_skid_fill_on_stall, clk, arst_n,
		$rose(skid_v_q) |-> $past(out_v_q && !m_axis_tready),
		"skid filled while output register was free")

endmodule
